// ===== design/eba_pkg.sv =====
// package for the eight-bit alu with status flags
// request and response structs, operation codes, condition codes, the sign_code helper
// no dependencies
`timescale 1ns / 1ps

package eba_pkg;

  localparam logic [3:0] OP_LOAD = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_AND  = 4'd3;
  localparam logic [3:0] OP_OR   = 4'd4;
  localparam logic [3:0] OP_XOR  = 4'd5;
  localparam logic [3:0] OP_CMP  = 4'd6;
  localparam logic [3:0] OP_DAJ  = 4'd7;
  localparam logic [3:0] OP_ROR  = 4'd8;
  localparam logic [3:0] OP_ROL  = 4'd9;
  localparam logic [3:0] OP_TST  = 4'd10;

  localparam logic [1:0] CC_ZERO = 2'd0;
  localparam logic [1:0] CC_POS  = 2'd1;
  localparam logic [1:0] CC_NEG  = 2'd2;

  localparam logic [7:0] SIGN_FLIP = 8'h80;
  localparam logic [3:0] DAJ_LOW   = 4'hA;
  localparam logic [3:0] DAJ_HIGH  = 4'hA;

  typedef struct packed {
    logic [3:0] opcode;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic       carry_in;
    logic       idc_in;
    logic       ovf_in;
    logic       with_carry;
    logic       logical_compare;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] result;
    logic       writes_result;
    logic       carry_out;
    logic       idc_out;
    logic       ovf_out;
    logic [1:0] cond_code;
  } alu_rsp_t;

  function automatic logic [1:0] sign_code(input logic [7:0] v);
    logic [1:0] cc;
    if (v == 8'd0) begin
      cc = CC_ZERO;
    end else if (v[7]) begin
      cc = CC_NEG;
    end else begin
      cc = CC_POS;
    end
    return cc;
  endfunction

endpackage

// ===== design/eba_alu.sv =====
// combinational alu core: one request in, one response out
// depends on eba_pkg
`timescale 1ns / 1ps

module eba_alu import eba_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [8:0] add_sum;
  logic [4:0] add_low;
  logic [8:0] sub_sum;
  logic [4:0] sub_low;
  logic       add_ci;
  logic       sub_nb;
  logic [7:0] cmp_x;
  logic [7:0] cmp_y;
  logic [3:0] daj_lo;
  logic [3:0] daj_hi;
  logic [7:0] r;

  assign add_ci  = req.with_carry & req.carry_in;
  assign add_sum = {1'b0, req.operand_a} + {1'b0, req.operand_b} + {8'd0, add_ci};
  assign add_low = {1'b0, req.operand_a[3:0]} + {1'b0, req.operand_b[3:0]} + {4'd0, add_ci};

  // no borrow in unless carry is used and clear
  assign sub_nb  = ~(req.with_carry & ~req.carry_in);
  assign sub_sum = {1'b0, req.operand_a} + {1'b0, ~req.operand_b} + {8'd0, sub_nb};
  assign sub_low = {1'b0, req.operand_a[3:0]} + {1'b0, ~req.operand_b[3:0]}
                 + {4'd0, sub_nb};

  assign cmp_x = req.logical_compare ? req.operand_a : (req.operand_a ^ SIGN_FLIP);
  assign cmp_y = req.logical_compare ? req.operand_b : (req.operand_b ^ SIGN_FLIP);

  assign daj_lo = req.idc_in   ? req.operand_a[3:0] : (req.operand_a[3:0] + DAJ_LOW);
  assign daj_hi = req.carry_in ? req.operand_a[7:4] : (req.operand_a[7:4] + DAJ_HIGH);

  always_comb begin
    rsp.result        = req.operand_a;
    rsp.writes_result = 1'b0;
    rsp.carry_out     = req.carry_in;
    rsp.idc_out       = req.idc_in;
    rsp.ovf_out       = req.ovf_in;
    rsp.cond_code     = CC_ZERO;
    r                 = req.operand_a;
    unique case (req.opcode)
      OP_LOAD: begin
        r = req.operand_b;
        rsp.writes_result = 1'b1;
      end
      OP_ADD: begin
        r = add_sum[7:0];
        rsp.writes_result = 1'b1;
        rsp.carry_out = add_sum[8];
        rsp.idc_out   = add_low[4];
        rsp.ovf_out   = (req.operand_a[7] ^ r[7]) & (req.operand_b[7] ^ r[7]);
      end
      OP_SUB: begin
        r = sub_sum[7:0];
        rsp.writes_result = 1'b1;
        rsp.carry_out = sub_sum[8];
        rsp.idc_out   = sub_low[4];
        rsp.ovf_out   = (req.operand_a[7] ^ req.operand_b[7]) & (req.operand_a[7] ^ r[7]);
      end
      OP_AND: begin
        r = req.operand_a & req.operand_b;
        rsp.writes_result = 1'b1;
      end
      OP_OR: begin
        r = req.operand_a | req.operand_b;
        rsp.writes_result = 1'b1;
      end
      OP_XOR: begin
        r = req.operand_a ^ req.operand_b;
        rsp.writes_result = 1'b1;
      end
      OP_DAJ: begin
        r = {daj_hi, daj_lo};
        rsp.writes_result = 1'b1;
      end
      OP_ROR: begin
        rsp.writes_result = 1'b1;
        if (req.with_carry) begin
          r = {req.carry_in, req.operand_a[7:1]};
          rsp.carry_out = req.operand_a[0];
          rsp.idc_out   = req.operand_a[4];
          rsp.ovf_out   = r[7] ^ req.operand_a[7];
        end else begin
          r = {req.operand_a[0], req.operand_a[7:1]};
        end
      end
      OP_ROL: begin
        rsp.writes_result = 1'b1;
        if (req.with_carry) begin
          r = {req.operand_a[6:0], req.carry_in};
          rsp.carry_out = req.operand_a[7];
          rsp.idc_out   = req.operand_a[3];
          rsp.ovf_out   = req.operand_a[6] ^ req.operand_a[7];
        end else begin
          r = {req.operand_a[6:0], req.operand_a[7]};
        end
      end
      default: begin
        r = req.operand_a;
      end
    endcase
    rsp.result = r;
    if (rsp.writes_result) begin
      rsp.cond_code = sign_code(r);
    end else if (req.opcode == OP_CMP) begin
      if (cmp_x == cmp_y) begin
        rsp.cond_code = CC_ZERO;
      end else if (cmp_x > cmp_y) begin
        rsp.cond_code = CC_POS;
      end else begin
        rsp.cond_code = CC_NEG;
      end
    end else if (req.opcode == OP_TST) begin
      rsp.cond_code = ((req.operand_a | ~req.operand_b) == 8'hFF) ? CC_ZERO : CC_NEG;
    end
  end

endmodule

// ===== design/eight_bit_alu_with_status_flags_top.sv =====
// top level of the eight-bit alu with status flags
// input register, alu core, result register; depends on eba_pkg and eba_alu
`timescale 1ns / 1ps

// usage
//   a request is taken at a rising edge where start is high and busy is low.
//   req carries the opcode, both operand bytes and the incoming flags.
//   the response appears on rsp with done high once the request has passed
//   the input register, the alu core and the result register, and is taken
//   at a rising edge where done is high.
//   one request per cycle is taken while busy is low; busy is low once reset
//   has been released, so requests may follow each other back to back.
//   pipeline: input register, then the result register behind the
//   single-pass alu core; throughput: 1 request per cycle.
//   the receiver cannot stall: each response is valid for one cycle only
//   and must be captured then.
//   reset (rst, synchronous, active high) drops every request in flight,
//   clears done and holds busy high until after rst is released.
//   unused opcodes return operand_a unwritten with flags unchanged and
//   condition code zero.
module eight_bit_alu_with_status_flags_top import eba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  alu_req_t req,
  output logic     done,
  output alu_rsp_t rsp
);

  logic     stage_valid;
  alu_req_t stage_req;
  alu_rsp_t rsp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b1;
      stage_valid <= 1'b0;
      done        <= 1'b0;
    end else begin
      busy        <= 1'b0;
      stage_valid <= start & ~busy;
      done        <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      stage_req <= req;
    end
    if (stage_valid) begin
      rsp <= rsp_next;
    end
  end

  eba_alu u_alu (
    .req (stage_req),
    .rsp (rsp_next)
  );

  // every response comes from an earlier accepted request
  a_done_from_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("response without request");

  // no-write operations leave carry, idc and ovf as they came in and return operand_a as the result
  a_nowrite_flags: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.writes_result |->
      rsp.carry_out == $past(req.carry_in, 2) &&
      rsp.idc_out == $past(req.idc_in, 2) &&
      rsp.ovf_out == $past(req.ovf_in, 2) &&
      rsp.result == $past(req.operand_a, 2))
    else $error("flags changed on no-write operation");

  // condition code never takes the unused encoding
  a_cc_range: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.cond_code != 2'd3)
    else $error("bad condition code");

endmodule

// ===== dv/testbench.sv =====
// testbench for eight_bit_alu_with_status_flags_top: a directed table, then random requests
// under three sender idle settings, checked field by field against fixed expected values or an in-bench alu predictor
// depends on eba_pkg and the design sources
`timescale 1ns / 1ps

module testbench;
  import eba_pkg::*;

  localparam logic [3:0] OP_SPARE_FIRST = 4'd11;
  localparam logic [3:0] OP_SPARE_LAST  = 4'd15;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_REQS  = 552;
  localparam int DRAIN_CYCLES = 6;

  typedef struct {
    alu_req_t q;
    logic     fixed;
    alu_rsp_t e;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  alu_req_t req = '0;
  logic     busy;
  logic     done;
  alu_rsp_t rsp;

  logic     fixed_exp = 1'b0;
  alu_rsp_t fixed_rsp = '0;

  dir_row_t dir_rows[$];
  alu_rsp_t pending_rsp_q[$];
  int       mismatches = 0;
  int       cycles = 0;
  int       idle_pct = 16;

  always #5 clk = ~clk;

  eight_bit_alu_with_status_flags_top i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  function automatic alu_req_t mk_req(logic [3:0] op, logic [7:0] a, logic [7:0] b,
                                      logic cy, logic idc, logic ovf, logic wc, logic lc);
    alu_req_t q;
    q.opcode          = op;
    q.operand_a       = a;
    q.operand_b       = b;
    q.carry_in        = cy;
    q.idc_in          = idc;
    q.ovf_in          = ovf;
    q.with_carry      = wc;
    q.logical_compare = lc;
    return q;
  endfunction

  function automatic alu_rsp_t mk_rsp(logic [7:0] r, logic wr, logic cy, logic idc,
                                      logic ovf, logic [1:0] cc);
    alu_rsp_t e;
    e.result        = r;
    e.writes_result = wr;
    e.carry_out     = cy;
    e.idc_out       = idc;
    e.ovf_out       = ovf;
    e.cond_code     = cc;
    return e;
  endfunction

  function automatic alu_rsp_t alu_expect(alu_req_t q);
    alu_rsp_t   e;
    logic [8:0] sum;
    logic [4:0] nib;
    logic       ci;
    logic [7:0] x;
    logic [7:0] y;
    e = mk_rsp(q.operand_a, 1'b0, q.carry_in, q.idc_in, q.ovf_in, CC_ZERO);
    case (q.opcode)
      OP_LOAD: begin
        e.result = q.operand_b;
        e.writes_result = 1'b1;
      end
      OP_ADD: begin
        ci = q.with_carry & q.carry_in;
        sum = {1'b0, q.operand_a} + {1'b0, q.operand_b} + {8'd0, ci};
        nib = {1'b0, q.operand_a[3:0]} + {1'b0, q.operand_b[3:0]} + {4'd0, ci};
        e.result = sum[7:0];
        e.carry_out = sum[8];
        e.idc_out = nib[4];
        e.ovf_out = (q.operand_a[7] ^ sum[7]) & (q.operand_b[7] ^ sum[7]);
        e.writes_result = 1'b1;
      end
      OP_SUB: begin
        ci = q.with_carry & ~q.carry_in;
        sum = {1'b0, q.operand_a} - {1'b0, q.operand_b} - {8'd0, ci};
        nib = {1'b0, q.operand_a[3:0]} - {1'b0, q.operand_b[3:0]} - {4'd0, ci};
        e.result = sum[7:0];
        e.carry_out = ~sum[8];
        e.idc_out = ~nib[4];
        e.ovf_out = (q.operand_a[7] ^ q.operand_b[7]) & (q.operand_a[7] ^ sum[7]);
        e.writes_result = 1'b1;
      end
      OP_AND: begin
        e.result = q.operand_a & q.operand_b;
        e.writes_result = 1'b1;
      end
      OP_OR: begin
        e.result = q.operand_a | q.operand_b;
        e.writes_result = 1'b1;
      end
      OP_XOR: begin
        e.result = q.operand_a ^ q.operand_b;
        e.writes_result = 1'b1;
      end
      OP_CMP: begin
        x = q.operand_a;
        y = q.operand_b;
        if (!q.logical_compare) begin
          x = x ^ SIGN_FLIP;
          y = y ^ SIGN_FLIP;
        end
        e.cond_code = (x == y) ? CC_ZERO : ((x > y) ? CC_POS : CC_NEG);
      end
      OP_DAJ: begin
        x = q.operand_a;
        if (!q.idc_in) begin
          x[3:0] = x[3:0] + DAJ_LOW;
        end
        if (!q.carry_in) begin
          x = x + {DAJ_HIGH, 4'h0};
        end
        e.result = x;
        e.writes_result = 1'b1;
      end
      OP_ROR: begin
        if (q.with_carry) begin
          e.result = {q.carry_in, q.operand_a[7:1]};
          e.carry_out = q.operand_a[0];
          e.idc_out = q.operand_a[4];
          e.ovf_out = q.carry_in ^ q.operand_a[7];
        end else begin
          e.result = {q.operand_a[0], q.operand_a[7:1]};
        end
        e.writes_result = 1'b1;
      end
      OP_ROL: begin
        if (q.with_carry) begin
          e.result = {q.operand_a[6:0], q.carry_in};
          e.carry_out = q.operand_a[7];
          e.idc_out = q.operand_a[3];
          e.ovf_out = q.operand_a[6] ^ q.operand_a[7];
        end else begin
          e.result = {q.operand_a[6:0], q.operand_a[7]};
        end
        e.writes_result = 1'b1;
      end
      OP_TST: begin
        e.cond_code = ((q.operand_a | ~q.operand_b) == 8'hFF) ? CC_ZERO : CC_NEG;
      end
      default: begin
      end
    endcase
    if (e.writes_result) begin
      e.cond_code = (e.result == 8'd0) ? CC_ZERO : (e.result[7] ? CC_NEG : CC_POS);
    end
    return e;
  endfunction

  function automatic logic [7:0] rand_operand();
    logic [7:0] v;
    v = 8'($urandom);
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: v = 8'h00;
        1: v = 8'hFF;
        2: v = 8'h7F;
        default: v = 8'h80;
      endcase
    end
    return v;
  endfunction

  function automatic alu_req_t rand_req();
    alu_req_t q;
    q = mk_req(OP_LOAD, rand_operand(), rand_operand(), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    if ($urandom_range(99) < 6) begin
      q.opcode = 4'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    end else begin
      q.opcode = 4'($urandom_range(OP_TST));
    end
    {q.carry_in, q.idc_in, q.ovf_in, q.with_carry, q.logical_compare} = 5'($urandom);
    if (q.opcode == OP_CMP && $urandom_range(3) == 0) begin
      q.operand_b = q.operand_a;
    end
    if (q.opcode == OP_TST && $urandom_range(1) == 0) begin
      q.operand_b = q.operand_a & q.operand_b;
    end
    return q;
  endfunction

  task automatic add_row(input alu_req_t q, input logic fixed, input alu_rsp_t e);
    dir_row_t row;
    row.q = q;
    row.fixed = fixed;
    row.e = e;
    dir_rows.push_back(row);
  endtask

  // holds the request until it is taken; start is left high for a back-to-back follower
  task automatic send_req(input alu_req_t q, input logic fixed, input alu_rsp_t e);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= q;
    fixed_exp <= fixed;
    fixed_rsp <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic check_rsp(input alu_rsp_t e, input alu_rsp_t got);
    if (got.result !== e.result || got.writes_result !== e.writes_result ||
        got.carry_out !== e.carry_out || got.idc_out !== e.idc_out ||
        got.ovf_out !== e.ovf_out || got.cond_code !== e.cond_code) begin
      mismatches++;
      if (mismatches <= 10) begin
        $write("%0t mismatch: exp r=%h wr=%b c=%b idc=%b ovf=%b cc=%0d,",
               $realtime, e.result, e.writes_result, e.carry_out, e.idc_out, e.ovf_out,
               e.cond_code);
        $display(" got r=%h wr=%b c=%b idc=%b ovf=%b cc=%0d",
                 got.result, got.writes_result, got.carry_out, got.idc_out,
                 got.ovf_out, got.cond_code);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      pending_rsp_q.push_back(fixed_exp ? fixed_rsp : alu_expect(req));
    end
    if (done) begin
      if (pending_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t unexpected response r=%h", $realtime, rsp.result);
        end
      end else begin
        check_rsp(pending_rsp_q.pop_front(), rsp);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** eight_bit_alu_with_status_flags_top: FAILED **");
      $finish;
    end
  end

  initial begin
    int phase;
    alu_rsp_t none;
    none = '0;

    add_row(mk_req(OP_LOAD, 8'h5A, 8'h00, 0, 0, 0, 0, 0), 1'b1,
            mk_rsp(8'h00, 1, 0, 0, 0, CC_ZERO));
    add_row(mk_req(OP_LOAD, 8'h00, 8'h80, 1, 1, 1, 1, 1), 1'b1,
            mk_rsp(8'h80, 1, 1, 1, 1, CC_NEG));
    add_row(mk_req(OP_ADD, 8'hFF, 8'h01, 1, 0, 1, 0, 0), 1'b1,
            mk_rsp(8'h00, 1, 1, 1, 0, CC_ZERO));
    add_row(mk_req(OP_ADD, 8'h7F, 8'h01, 0, 0, 0, 0, 0), 1'b1,
            mk_rsp(8'h80, 1, 0, 1, 1, CC_NEG));
    // carry-in rippling into the interdigit carry
    add_row(mk_req(OP_ADD, 8'h0F, 8'h00, 1, 0, 0, 1, 0), 1'b0, none);
    add_row(mk_req(OP_SUB, 8'h00, 8'h01, 1, 1, 0, 0, 0), 1'b1,
            mk_rsp(8'hFF, 1, 0, 0, 0, CC_NEG));
    add_row(mk_req(OP_SUB, 8'h80, 8'h01, 0, 1, 0, 0, 0), 1'b1,
            mk_rsp(8'h7F, 1, 1, 0, 1, CC_POS));
    // borrow-in across the low digit
    add_row(mk_req(OP_SUB, 8'h10, 8'h00, 0, 0, 1, 1, 0), 1'b0, none);
    add_row(mk_req(OP_AND, 8'hFF, 8'h0F, 0, 1, 0, 1, 0), 1'b0, none);
    add_row(mk_req(OP_OR, 8'h00, 8'h00, 1, 0, 1, 0, 1), 1'b0, none);
    add_row(mk_req(OP_XOR, 8'hAA, 8'h55, 0, 0, 0, 0, 0), 1'b0, none);
    add_row(mk_req(OP_CMP, 8'h80, 8'h7F, 0, 0, 0, 0, 0), 1'b1,
            mk_rsp(8'h80, 0, 0, 0, 0, CC_NEG));
    add_row(mk_req(OP_CMP, 8'h80, 8'h7F, 1, 1, 1, 1, 1), 1'b1,
            mk_rsp(8'h80, 0, 1, 1, 1, CC_POS));
    add_row(mk_req(OP_CMP, 8'h5A, 8'h5A, 0, 1, 0, 1, 0), 1'b1,
            mk_rsp(8'h5A, 0, 0, 1, 0, CC_ZERO));
    add_row(mk_req(OP_DAJ, 8'h9A, 8'h00, 0, 0, 0, 0, 0), 1'b0, none);
    add_row(mk_req(OP_DAJ, 8'h55, 8'hFF, 1, 1, 1, 1, 1), 1'b0, none);
    add_row(mk_req(OP_ROR, 8'h01, 8'h00, 0, 0, 0, 1, 0), 1'b0, none);
    add_row(mk_req(OP_ROR, 8'h81, 8'h00, 1, 1, 1, 0, 0), 1'b0, none);
    add_row(mk_req(OP_ROL, 8'h80, 8'h00, 1, 0, 0, 1, 0), 1'b0, none);
    add_row(mk_req(OP_ROL, 8'h40, 8'h00, 0, 1, 1, 0, 1), 1'b0, none);
    add_row(mk_req(OP_TST, 8'hFF, 8'hFF, 1, 0, 0, 0, 0), 1'b1,
            mk_rsp(8'hFF, 0, 1, 0, 0, CC_ZERO));
    add_row(mk_req(OP_TST, 8'h00, 8'h01, 0, 0, 1, 0, 0), 1'b1,
            mk_rsp(8'h00, 0, 0, 0, 1, CC_NEG));
    add_row(mk_req(OP_SPARE_FIRST, 8'h5A, 8'hA5, 1, 0, 1, 1, 1), 1'b1,
            mk_rsp(8'h5A, 0, 1, 0, 1, CC_ZERO));
    add_row(mk_req(OP_SPARE_LAST, 8'hFF, 8'h00, 0, 1, 0, 0, 0), 1'b1,
            mk_rsp(8'hFF, 0, 0, 1, 0, CC_ZERO));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].q, dir_rows[i].fixed, dir_rows[i].e);
    end

    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 16 : ((phase == 1) ? 71 : 0);
      repeat (RANDOM_REQS / 3) send_req(rand_req(), 1'b0, none);
    end
    start <= 1'b0;

    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** eight_bit_alu_with_status_flags_top: PASSED **");
    end else begin
      $display("** eight_bit_alu_with_status_flags_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/eba_pkg.sv
design/eba_alu.sv
design/eight_bit_alu_with_status_flags_top.sv
dv/testbench.sv
